// ===== design/trle_pkg.sv =====
// Shared types and constants for the transparent run-length encoder.
`timescale 1ns / 1ps
package trle_pkg;

  // Fixed field widths of the encoded stream.
  localparam int WORD_BITS = 16;
  localparam int POS_BITS  = 21;
  localparam int RUN_BITS  = 8;
  localparam int CFG_BITS  = 11;
  localparam int ROW_BITS  = 10;
  localparam int ROW_LIMIT = 1024;

  // Configuration port geometry.
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // Register index taken from paddr[2].
  localparam logic REG_ROW_WIDTH = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  // Result slots of one input pixel, in emission order.
  localparam int SLOT_COUNT     = 3;
  localparam int SLOT_SPLIT     = 0;
  localparam int SLOT_PIXEL     = 1;
  localparam int SLOT_ROW_CLOSE = 2;

  typedef struct packed {
    logic [WORD_BITS-1:0] pixel_value;
    logic                 is_transparent;
  } pixel_in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] out_word;
    logic [POS_BITS-1:0]  out_position;
    logic                 is_code;
    logic                 image_done;
    logic                 last_of_run;
  } result_t;

  // All results caused by one pixel, with a valid bit per slot.
  typedef struct packed {
    result_t [SLOT_COUNT-1:0] slot;
    logic    [SLOT_COUNT-1:0] valid;
  } bundle_t;

endpackage

// ===== design/transparent_run_length_encoder.sv =====
// Top level of the transparent run-length encoder with its register port.
// Results of a pixel appear in the cycle after its transfer, one per cycle while
// out_stall_i is low. Throughput: one pixel per cycle while out_stall_i is low;
// a pixel with two or three results holds the input while the register drains.
// Reset: asynchronous, active low; clears segment state, empties the result
// register and sets row_width and row_count to 1.
`timescale 1ns / 1ps
module transparent_run_length_encoder #(
  parameter int PIXEL_BITS = 16,
  parameter int MAX_RUN    = 255,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  trle_pkg::pixel_in_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output trle_pkg::result_t                 out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [trle_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [trle_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [trle_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import trle_pkg::*;

  logic [CFG_BITS-1:0] row_width_q, row_width_d;
  logic [CFG_BITS-1:0] row_count_q, row_count_d;
  logic                cfg_write, reg_sel, in_accept, can_load;
  bundle_t             bundle;

  // Register port: always ready, index from the word address.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    row_width_d = row_width_q;
    row_count_d = row_count_q;
    prdata      = '0;
    case (reg_sel)
      REG_ROW_WIDTH: begin
        prdata = APB_DATA_BITS'(row_width_q);
        if (cfg_write) row_width_d = pwdata[CFG_BITS-1:0];
      end
      REG_ROW_COUNT: begin
        prdata = APB_DATA_BITS'(row_count_q);
        if (cfg_write) row_count_d = pwdata[CFG_BITS-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= CFG_BITS'(1);
      row_count_q <= CFG_BITS'(1);
    end else begin
      row_width_q <= row_width_d;
      row_count_q <= row_count_d;
    end
  end

  // A pixel transfer happens whenever the result register can take its results.
  assign in_stall_o = !can_load;
  assign in_accept  = in_valid_i && can_load;

  trle_encoder #(
    .PIXEL_BITS(PIXEL_BITS),
    .MAX_RUN   (MAX_RUN),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_encoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .pixel_i    (in_data_i),
    .row_width_i(row_width_q),
    .row_count_i(row_count_q),
    .bundle_o   (bundle)
  );

  trle_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_accept),
    .bundle_i   (bundle),
    .can_load_o (can_load),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // An empty result register never holds back the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result pending");

  // The image-done flag only rides on the closing code of a pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.image_done |-> out_data_o.is_code && out_data_o.last_of_run)
    else $error("image done on a result that is not a final code");

  // Results of one pixel follow each other without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("results of one pixel were cut short");

  // A pixel is taken in only when its predecessor's last result leaves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && out_valid_o |-> !out_stall_i && out_data_o.last_of_run)
    else $error("pixel taken while earlier results were still pending");

endmodule

// ===== design/trle_encoder.sv =====
// Segment state and the single-pass encoding step for one pixel.
`timescale 1ns / 1ps
module trle_encoder #(
  parameter int PIXEL_BITS = 16,
  parameter int MAX_RUN    = 255,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  trle_pkg::pixel_in_t          pixel_i,
  input  logic [trle_pkg::CFG_BITS-1:0] row_width_i,
  input  logic [trle_pkg::CFG_BITS-1:0] row_count_i,
  output trle_pkg::bundle_t            bundle_o
);
  import trle_pkg::*;

  localparam int ColBits = $clog2(MAX_WIDTH);
  localparam int WidBits = $clog2(MAX_WIDTH + 1);
  localparam int CmpBits = (WidBits > CFG_BITS) ? WidBits : CFG_BITS;
  localparam logic [RUN_BITS-1:0]  RunMax   = RUN_BITS'(MAX_RUN);
  localparam logic [CmpBits-1:0]   WidthMax = CmpBits'(MAX_WIDTH);
  localparam logic [CFG_BITS-1:0]  RowMax   = CFG_BITS'(ROW_LIMIT);
  localparam logic [WORD_BITS-1:0] PixMask  =
    (PIXEL_BITS >= WORD_BITS) ? {WORD_BITS{1'b1}} : WORD_BITS'((64'd1 << PIXEL_BITS) - 64'd1);

  logic [ColBits-1:0]  column_q, column_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic                opaque_phase_q, opaque_phase_d;
  logic                seg_open_q, seg_open_d;
  logic [RUN_BITS-1:0] clear_q, clear_d;
  logic [RUN_BITS-1:0] solid_q, solid_d;
  logic [POS_BITS-1:0] code_slot_q, code_slot_d;
  logic [POS_BITS-1:0] next_slot_q, next_slot_d;

  logic [CmpBits-1:0]  width_eff, column_next;
  logic [CFG_BITS-1:0] height_eff, row_next;
  logic                transparent, opaque, seg_new, close_mid, row_end, last_row;
  logic [RUN_BITS-1:0] clear0, solid0, clear1, solid1, clear2, solid2;
  logic                phase0, phase1, phase2;
  logic [POS_BITS-1:0] slot0, open_slot, slot1, pixel_pos, next_slot2;

  // Clamp the region registers into their meaningful ranges.
  always_comb begin
    if (CmpBits'(row_width_i) == '0) begin
      width_eff = CmpBits'(1);
    end else if (CmpBits'(row_width_i) > WidthMax) begin
      width_eff = WidthMax;
    end else begin
      width_eff = CmpBits'(row_width_i);
    end
    if (row_count_i == '0) begin
      height_eff = CFG_BITS'(1);
    end else if (row_count_i > RowMax) begin
      height_eff = RowMax;
    end else begin
      height_eff = row_count_i;
    end
  end

  // Open, split and advance the segment for the incoming pixel.
  always_comb begin
    transparent = pixel_i.is_transparent;
    opaque      = !pixel_i.is_transparent;
    seg_new     = !seg_open_q;

    // A closed segment reopens at the next free slot with empty counts.
    slot0     = seg_open_q ? code_slot_q : next_slot_q;
    clear0    = seg_open_q ? clear_q : '0;
    solid0    = seg_open_q ? solid_q : '0;
    phase0    = seg_open_q && opaque_phase_q;
    open_slot = next_slot_q + POS_BITS'(seg_new);

    // A full run or a return to transparency splits the segment.
    if (transparent) begin
      close_mid = phase0 || (clear0 >= RunMax);
    end else begin
      close_mid = phase0 && (solid0 >= RunMax);
    end

    slot1      = close_mid ? open_slot : slot0;
    clear1     = close_mid ? '0 : clear0;
    solid1     = close_mid ? '0 : solid0;
    phase1     = close_mid ? 1'b0 : phase0;
    pixel_pos  = open_slot + POS_BITS'(close_mid);
    next_slot2 = pixel_pos + POS_BITS'(opaque);
    clear2     = clear1 + RUN_BITS'(transparent);
    solid2     = solid1 + RUN_BITS'(opaque);
    phase2     = phase1 || opaque;

    column_next = CmpBits'(column_q) + CmpBits'(1);
    row_next    = CFG_BITS'(row_q) + CFG_BITS'(1);
    row_end     = column_next >= width_eff;
    last_row    = row_next >= height_eff;
  end

  // Collect the results of this pixel in emission order.
  always_comb begin
    bundle_o = '0;
    bundle_o.valid[SLOT_SPLIT]     = close_mid;
    bundle_o.valid[SLOT_PIXEL]     = opaque;
    bundle_o.valid[SLOT_ROW_CLOSE] = row_end;

    bundle_o.slot[SLOT_SPLIT].out_word     = {clear0, solid0};
    bundle_o.slot[SLOT_SPLIT].out_position = slot0;
    bundle_o.slot[SLOT_SPLIT].is_code      = 1'b1;

    bundle_o.slot[SLOT_PIXEL].out_word     = pixel_i.pixel_value & PixMask;
    bundle_o.slot[SLOT_PIXEL].out_position = pixel_pos;

    bundle_o.slot[SLOT_ROW_CLOSE].out_word     = {clear2, solid2};
    bundle_o.slot[SLOT_ROW_CLOSE].out_position = slot1;
    bundle_o.slot[SLOT_ROW_CLOSE].is_code      = 1'b1;
    bundle_o.slot[SLOT_ROW_CLOSE].image_done   = last_row;

    // Mark the final result that this pixel causes.
    if (row_end) begin
      bundle_o.slot[SLOT_ROW_CLOSE].last_of_run = 1'b1;
    end else if (opaque) begin
      bundle_o.slot[SLOT_PIXEL].last_of_run = 1'b1;
    end else begin
      bundle_o.slot[SLOT_SPLIT].last_of_run = 1'b1;
    end
  end

  // Next state of the segment tracker.
  always_comb begin
    column_d       = column_q;
    row_d          = row_q;
    opaque_phase_d = opaque_phase_q;
    seg_open_d     = seg_open_q;
    clear_d        = clear_q;
    solid_d        = solid_q;
    code_slot_d    = code_slot_q;
    next_slot_d    = next_slot_q;
    if (accept_i) begin
      column_d       = ColBits'(column_next);
      seg_open_d     = 1'b1;
      code_slot_d    = slot1;
      next_slot_d    = next_slot2;
      clear_d        = clear2;
      solid_d        = solid2;
      opaque_phase_d = phase2;
      if (row_end) begin
        column_d   = '0;
        seg_open_d = 1'b0;
        if (last_row) begin
          // The image is complete: start the next one at position zero.
          row_d          = '0;
          code_slot_d    = '0;
          next_slot_d    = '0;
          clear_d        = '0;
          solid_d        = '0;
          opaque_phase_d = 1'b0;
        end else begin
          row_d = row_q + ROW_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q       <= '0;
      row_q          <= '0;
      opaque_phase_q <= 1'b0;
      seg_open_q     <= 1'b0;
      clear_q        <= '0;
      solid_q        <= '0;
      code_slot_q    <= '0;
      next_slot_q    <= '0;
    end else begin
      column_q       <= column_d;
      row_q          <= row_d;
      opaque_phase_q <= opaque_phase_d;
      seg_open_q     <= seg_open_d;
      clear_q        <= clear_d;
      solid_q        <= solid_d;
      code_slot_q    <= code_slot_d;
      next_slot_q    <= next_slot_d;
    end
  end

endmodule

// ===== design/trle_out_buf.sv =====
// Result register that holds one pixel's results and sends them one per transfer.
`timescale 1ns / 1ps
module trle_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  trle_pkg::bundle_t bundle_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output trle_pkg::result_t out_data_o
);
  import trle_pkg::*;

  result_t [SLOT_COUNT-1:0] slot_q, slot_d;
  logic    [SLOT_COUNT-1:0] valid_q, valid_d;
  logic    [SLOT_COUNT-1:0] take;
  logic                     out_xfer;

  // Send the earliest pending slot.
  always_comb begin
    take       = '0;
    out_data_o = slot_q[SLOT_ROW_CLOSE];
    if (valid_q[SLOT_SPLIT]) begin
      take[SLOT_SPLIT] = 1'b1;
      out_data_o       = slot_q[SLOT_SPLIT];
    end else if (valid_q[SLOT_PIXEL]) begin
      take[SLOT_PIXEL] = 1'b1;
      out_data_o       = slot_q[SLOT_PIXEL];
    end else begin
      take[SLOT_ROW_CLOSE] = valid_q[SLOT_ROW_CLOSE];
    end
  end

  assign out_valid_o = |valid_q;
  assign out_xfer    = out_valid_o && !out_stall_i;

  // A new pixel fits once at most the last pending result leaves this cycle.
  assign can_load_o = (valid_q == '0) || (($countones(valid_q) == 1) && !out_stall_i);

  always_comb begin
    slot_d  = slot_q;
    valid_d = valid_q;
    if (out_xfer) begin
      valid_d = valid_q & ~take;
    end
    if (load_i) begin
      slot_d  = bundle_i.slot;
      valid_d = bundle_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule
